// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the hover height PID block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hhp_pkg.sv =====
// Shared types and constants for the hover height PID block.
// Used by the controller, datapath and top level; no dependencies.
package hhp_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG    = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV    = 3'd2;
  localparam logic [2:0] REG_ADJUST_LIMIT  = 3'd3;
  localparam logic [2:0] REG_TARGET_HEIGHT = 3'd4;

  // Register reset values
  localparam logic [31:0] RST_GAIN_PROP     = 32'd6553600;
  localparam logic [31:0] RST_GAIN_INTEG    = 32'd0;
  localparam logic [31:0] RST_GAIN_DERIV    = 32'd327680;
  localparam logic [30:0] RST_ADJUST_LIMIT  = 31'd65536000;
  localparam logic [19:0] RST_TARGET_HEIGHT = 20'd131072;

  // Magnitude bits of (error - last error)
  localparam int DIFF_W = 21;
  localparam int DT_W   = 17;

  // Gain term magnitude cap and force ceiling
  localparam logic [63:0] TERM_CAP  = 64'h1000_0000_0000_0000;
  localparam logic [47:0] FORCE_MAX = 48'hFFFF_FFFF_FFFF;

  // Shared multiplier operand select
  localparam logic [2:0] MUL_EDT = 3'd0;
  localparam logic [2:0] MUL_P   = 3'd1;
  localparam logic [2:0] MUL_IL  = 3'd2;
  localparam logic [2:0] MUL_IH  = 3'd3;
  localparam logic [2:0] MUL_D   = 3'd4;
  localparam logic [2:0] MUL_F   = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       start;
    logic       integ_upd;
    logic       p_load;
    logic       lo_save;
    logic       i_add;
    logic       deriv_save;
    logic       d_add;
    logic       clamp;
    logic       force_save;
    logic       out_load;
    logic [2:0] mul_op;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic div_done;
  } sts_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== hdl/hhp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// Used by the datapath for the derivative; no package dependencies.
`include "assert_macros.svh"

module hhp_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_comb begin
    if (fits) begin
      rem_nxt = DEN_W'(trial - {1'b0, den});
    end else begin
      rem_nxt = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (run_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  `HHP_ASSERT_IMP(a_div_full_count, $rose(done_r),
    $past(run_r) && ($past(cnt_r) == CNT_W'(1)), "divider finished early")

endmodule

// ===== hdl/hhp_datapath.sv =====
// Datapath: config registers, PID state, shared multiplier, divider, output beat.
// Depends on hhp_pkg and hhp_div; sequenced by hhp_ctrl through cmd_t.
`include "assert_macros.svh"

module hhp_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hhp_pkg::cmd_t cmd,
  output hhp_pkg::sts_t sts,
  input  logic          in_ground_hit,
  input  logic [19:0]   in_height,
  input  logic [16:0]   in_tick_length,
  input  logic [31:0]   in_body_mass,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic [47:0]   out_lift_force,
  output logic          out_force_applied
);

  localparam int NUM_W = hhp_pkg::DIFF_W + FRAC_BITS;
  localparam int QX_W  = (NUM_W > 33) ? NUM_W : 33;

  // configuration
  logic [31:0] gp_r, gi_r, gd_r;
  logic [30:0] lim_r;
  logic [19:0] tgt_r;

  // PID state
  logic [20:0] last_err_r;
  logic [47:0] integ_r;

  // per-item working registers
  logic        hit_r;
  logic [20:0] err_r;
  logic [16:0] dt_r;
  logic [31:0] mass_r;
  logic [63:0] mul_r;
  logic [55:0] lo_r;
  logic [63:0] acc_r;
  logic        dneg_r;
  logic [31:0] dmag_r;
  logic [30:0] adj_r;
  logic [47:0] force_r;
  logic        fapp_r;
  logic [47:0] lift_r;
  logic        app_r;

  logic [20:0] err_in;
  logic [20:0] err_abs;
  logic [21:0] diff;
  logic [21:0] diff_abs;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] div_quo;
  logic        div_done;
  logic [47:0] integ_abs;
  logic [31:0] gp_abs, gi_abs, gd_abs;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_sh;
  logic [48:0] integ_sum;
  logic [47:0] integ_nxt;
  logic [79:0] ifull;
  logic [79:0] ish;
  logic [63:0] ival;
  logic [QX_W-1:0] q_ext;
  logic [QX_W-1:0] q_lim;
  logic [30:0] adj_nxt;

  assign err_in   = {1'b0, tgt_r} - {1'b0, in_height};
  assign err_abs  = err_r[20] ? (~err_r + 21'd1) : err_r;
  assign diff     = {err_r[20], err_r} - {last_err_r[20], last_err_r};
  assign diff_abs = diff[21] ? (~diff + 22'd1) : diff;
  assign div_num  = {diff_abs[20:0], {FRAC_BITS{1'b0}}};
  assign integ_abs = integ_r[47] ? (~integ_r + 48'd1) : integ_r;
  assign gp_abs   = hhp_pkg::mag32(gp_r);
  assign gi_abs   = hhp_pkg::mag32(gi_r);
  assign gd_abs   = hhp_pkg::mag32(gd_r);
  assign mul_sh   = mul_r >> FRAC_BITS;

  hhp_div #(
    .NUM_W (NUM_W),
    .DEN_W (hhp_pkg::DT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && hit_r),
    .num   (div_num),
    .den   (dt_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    case (cmd.mul_op)
      hhp_pkg::MUL_EDT: begin
        mul_a = {11'd0, err_abs};
        mul_b = {15'd0, dt_r};
      end
      hhp_pkg::MUL_P: begin
        mul_a = gp_abs;
        mul_b = {11'd0, err_abs};
      end
      hhp_pkg::MUL_IL: begin
        mul_a = gi_abs;
        mul_b = {8'd0, integ_abs[23:0]};
      end
      hhp_pkg::MUL_IH: begin
        mul_a = gi_abs;
        mul_b = {8'd0, integ_abs[47:24]};
      end
      hhp_pkg::MUL_D: begin
        mul_a = gd_abs;
        mul_b = dmag_r;
      end
      hhp_pkg::MUL_F: begin
        mul_a = {1'b0, adj_r};
        mul_b = mass_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integral += error * dt, saturating to 48 bits
  always_comb begin
    if (err_r[20]) begin
      integ_sum = {integ_r[47], integ_r} - 49'(mul_sh);
    end else begin
      integ_sum = {integ_r[47], integ_r} + 49'(mul_sh);
    end
    if (integ_sum[48] != integ_sum[47]) begin
      integ_nxt = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      integ_nxt = integ_sum[47:0];
    end
  end

  // integral gain term from the two partial products
  assign ifull = {mul_r[55:0], 24'd0} + {24'd0, lo_r};
  assign ish   = ifull >> FRAC_BITS;
  assign ival  = (ish > {16'd0, hhp_pkg::TERM_CAP}) ? hhp_pkg::TERM_CAP : ish[63:0];

  // derivative saturation to 32 bits signed
  assign q_ext = QX_W'(div_quo);
  assign q_lim = dneg_r ? QX_W'(33'h0_8000_0000) : QX_W'(33'h0_7FFF_FFFF);

  always_comb begin
    if (acc_r[63]) begin
      adj_nxt = '0;
    end else if (acc_r > {33'd0, lim_r}) begin
      adj_nxt = lim_r;
    end else begin
      adj_nxt = acc_r[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r       <= hhp_pkg::RST_GAIN_PROP;
      gi_r       <= hhp_pkg::RST_GAIN_INTEG;
      gd_r       <= hhp_pkg::RST_GAIN_DERIV;
      lim_r      <= hhp_pkg::RST_ADJUST_LIMIT;
      tgt_r      <= hhp_pkg::RST_TARGET_HEIGHT;
      integ_r    <= '0;
      last_err_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hhp_pkg::REG_GAIN_PROP:     gp_r  <= cfg_data;
          hhp_pkg::REG_GAIN_INTEG:    gi_r  <= cfg_data;
          hhp_pkg::REG_GAIN_DERIV:    gd_r  <= cfg_data;
          hhp_pkg::REG_ADJUST_LIMIT:  lim_r <= cfg_data[30:0];
          hhp_pkg::REG_TARGET_HEIGHT: tgt_r <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        if (hit_r) begin
          last_err_r <= err_r;
        end else begin
          integ_r    <= '0;
          last_err_r <= '0;
        end
      end
      if (cmd.integ_upd) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (cmd.accept) begin
      hit_r  <= in_ground_hit;
      err_r  <= err_in;
      dt_r   <= (in_tick_length == 17'd0) ? 17'd1 : in_tick_length;
      mass_r <= in_body_mass;
    end
    if (cmd.start) begin
      dneg_r <= diff[21];
      if (!hit_r) begin
        force_r <= '0;
        fapp_r  <= 1'b0;
      end
    end
    if (cmd.p_load) begin
      acc_r <= (gp_r[31] ^ err_r[20]) ? (64'd0 - mul_sh) : mul_sh;
    end
    if (cmd.lo_save) begin
      lo_r <= mul_r[55:0];
    end
    if (cmd.i_add) begin
      acc_r <= (gi_r[31] ^ integ_r[47]) ? (acc_r - ival) : (acc_r + ival);
    end
    if (cmd.deriv_save) begin
      dmag_r <= (q_ext > q_lim) ? q_lim[31:0] : q_ext[31:0];
    end
    if (cmd.d_add) begin
      acc_r <= (gd_r[31] ^ dneg_r) ? (acc_r - mul_sh) : (acc_r + mul_sh);
    end
    if (cmd.clamp) begin
      adj_r <= adj_nxt;
    end
    if (cmd.force_save) begin
      force_r <= (mul_sh > {16'd0, hhp_pkg::FORCE_MAX}) ? hhp_pkg::FORCE_MAX : mul_sh[47:0];
      fapp_r  <= 1'b1;
    end
    if (cmd.out_load) begin
      lift_r <= force_r;
      app_r  <= fapp_r;
    end
  end

  assign sts.hit      = hit_r;
  assign sts.div_done = div_done;

  assign out_lift_force    = lift_r;
  assign out_force_applied = app_r;

  `HHP_ASSERT_NXT(a_clamp_bound, cmd.clamp, adj_r <= lim_r, "adjustment above limit")
  `HHP_ASSERT_NXT(a_miss_clear, cmd.start && !hit_r,
    (integ_r == '0) && (last_err_r == '0) && !fapp_r && (force_r == '0),
    "miss did not clear state")

endmodule

// ===== hdl/hhp_ctrl.sv =====
// Sequencer for one control tick: issues datapath commands step by step.
// Depends on hhp_pkg for cmd_t, sts_t and the multiplier select codes.
`include "assert_macros.svh"

module hhp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  hhp_pkg::sts_t sts,
  output hhp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_P     = 4'd2;
  localparam logic [3:0] S_IL    = 4'd3;
  localparam logic [3:0] S_IH    = 4'd4;
  localparam logic [3:0] S_IS    = 4'd5;
  localparam logic [3:0] S_DW    = 4'd6;
  localparam logic [3:0] S_DM    = 4'd7;
  localparam logic [3:0] S_DS    = 4'd8;
  localparam logic [3:0] S_CLAMP = 4'd9;
  localparam logic [3:0] S_FM    = 4'd10;
  localparam logic [3:0] S_FS    = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mul_op = hhp_pkg::MUL_EDT;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.start  = 1'b1;
        cmd.mul_op = hhp_pkg::MUL_EDT;
        state_nxt  = sts.hit ? S_P : S_DONE;
      end
      S_P: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_op    = hhp_pkg::MUL_P;
        state_nxt     = S_IL;
      end
      S_IL: begin
        cmd.p_load = 1'b1;
        cmd.mul_op = hhp_pkg::MUL_IL;
        state_nxt  = S_IH;
      end
      S_IH: begin
        cmd.lo_save = 1'b1;
        cmd.mul_op  = hhp_pkg::MUL_IH;
        state_nxt   = S_IS;
      end
      S_IS: begin
        cmd.i_add = 1'b1;
        state_nxt = S_DW;
      end
      S_DW: begin
        if (sts.div_done) begin
          cmd.deriv_save = 1'b1;
          state_nxt      = S_DM;
        end
      end
      S_DM: begin
        cmd.mul_op = hhp_pkg::MUL_D;
        state_nxt  = S_DS;
      end
      S_DS: begin
        cmd.d_add = 1'b1;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_FM;
      end
      S_FM: begin
        cmd.mul_op = hhp_pkg::MUL_F;
        state_nxt  = S_FS;
      end
      S_FS: begin
        cmd.force_save = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a taken beat is never shown again unless a new result was loaded
  `HHP_ASSERT_NXT(a_no_dup_beat, out_valid_r && !out_stall,
    !out_valid_r || $past(cmd.out_load), "result beat repeated")

endmodule

// ===== hdl/hover_height_pid.sv =====
// Top level of the hover height PID controller with output clamp.
// Joins hhp_ctrl and hhp_datapath; depends on hhp_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  ground_hit, height, tick_length, body_mass
//   out_     output     out_valid / out_stall lift_force, force_applied
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// A ground hit runs the full sequence from accept to the next accept, held by the
// bit-serial derivative divide; a miss goes straight to the output beat.
// One item is in work at a time; the finished beat waits in an output register
// while the next item is taken. out_stall holds the sequencer only when a new
// result is ready and the previous beat is still waiting. rst_n is synchronous.
module hover_height_pid #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_ground_hit,
  input  logic [19:0] in_height,
  input  logic [16:0] in_tick_length,
  input  logic [31:0] in_body_mass,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_lift_force,
  output logic        out_force_applied,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  hhp_pkg::cmd_t cmd;
  hhp_pkg::sts_t sts;

  hhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hhp_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_ground_hit     (in_ground_hit),
    .in_height         (in_height),
    .in_tick_length    (in_tick_length),
    .in_body_mass      (in_body_mass),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_lift_force    (out_lift_force),
    .out_force_applied (out_force_applied)
  );

endmodule
